[rtl/sld_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sld_pkg;

  localparam logic [7:0] SYNC_0 = 8'h41;
  localparam logic [7:0] SYNC_1 = 8'h42;
  localparam logic [7:0] SYNC_2 = 8'h43;
  localparam logic [7:0] SYNC_3 = 8'h44;

  localparam int unsigned CountWidth = 15;
  localparam logic [CountWidth-1:0] CountReset = 15'd1024;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_A       = 7'b0000010,
    PH_AB      = 7'b0000100,
    PH_ABC     = 7'b0001000,
    PH_LEN_LO  = 7'b0010000,
    PH_LEN_HI  = 7'b0100000,
    PH_SAMPLES = 7'b1000000
  } phase_e;

endpackage

`default_nettype wire

[rtl/sync_length_frame_deframer_unit.sv]
// a result is registered: it is valid in the cycle after the byte that causes it is accepted
// throughput: one byte per cycle; the result register reloads in the cycle it is read,
// so input stalls only while a held result sees out_stall_i high
// reset (rst_ni low, asynchronous): hunting with no letters matched, counters cleared,
// expected_count back to 1024, no result pending
`timescale 1ns / 1ps
`default_nettype none

module sync_length_frame_deframer_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [7:0]                      rx_byte_i,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [sld_pkg::CountWidth-1:0]  cfg_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [1:0]                           kind_o,
  output logic signed [15:0]                   sample_o,
  output logic [sld_pkg::CountWidth-1:0]       reported_count_o,
  output logic                                 last_o
);
  import sld_pkg::*;

  phase_e                phase_q, phase_d;
  logic [15:0]           frame_length_q, frame_length_d;
  logic [7:0]            low_byte_q, low_byte_d;
  logic [15:0]           samples_done_q, samples_done_d;
  logic                  pair_half_q, pair_half_d;
  logic [CountWidth-1:0] expected_count_q;

  logic                  out_valid_q, out_valid_d;
  kind_e                 kind_q, kind_d;
  logic [15:0]           sample_q, sample_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic                  last_q, last_d;

  logic                  in_acc;
  logic                  emit;
  logic [15:0]           len_w;
  logic [CountWidth-1:0] len_count;
  logic [15:0]           done_inc;

  function automatic phase_e hunt_next(phase_e cur, logic [7:0] b);
    logic [7:0] want;
    phase_e     nxt;
    want = SYNC_0;
    nxt  = PH_A;
    case (cur)
      PH_A: begin
        want = SYNC_1;
        nxt  = PH_AB;
      end
      PH_AB: begin
        want = SYNC_2;
        nxt  = PH_ABC;
      end
      PH_ABC: begin
        want = SYNC_3;
        nxt  = PH_LEN_LO;
      end
      default: begin
        want = SYNC_0;
        nxt  = PH_A;
      end
    endcase
    if (b == want) begin
      return nxt;
    end else if (b == SYNC_0) begin
      return PH_A;
    end
    return PH_HUNT;
  endfunction

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign len_w     = {rx_byte_i, low_byte_q};
  assign len_count = len_w[15:1];
  assign done_inc  = samples_done_q + 16'd1;

  always_comb begin
    phase_d        = phase_q;
    frame_length_d = frame_length_q;
    low_byte_d     = low_byte_q;
    samples_done_d = samples_done_q;
    pair_half_d    = pair_half_q;
    emit           = 1'b0;
    kind_d         = kind_q;
    sample_d       = sample_q;
    count_d        = count_q;
    last_d         = last_q;
    if (in_acc) begin
      unique case (phase_q)
        PH_LEN_LO: begin
          low_byte_d = rx_byte_i;
          phase_d    = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          frame_length_d = len_w;
          low_byte_d     = 8'd0;
          emit           = 1'b1;
          sample_d       = 16'd0;
          count_d        = len_count;
          if (len_count == expected_count_q) begin
            kind_d         = KIND_ACCEPT;
            last_d         = (len_w == 16'd0);
            samples_done_d = 16'd0;
            pair_half_d    = 1'b0;
            phase_d        = (len_w == 16'd0) ? PH_HUNT : PH_SAMPLES;
          end else begin
            kind_d  = KIND_REJECT;
            last_d  = 1'b0;
            phase_d = PH_HUNT;
          end
        end
        PH_SAMPLES: begin
          if (!pair_half_q) begin
            low_byte_d  = rx_byte_i;
            pair_half_d = 1'b1;
          end else begin
            pair_half_d    = 1'b0;
            samples_done_d = done_inc;
            emit           = 1'b1;
            kind_d         = KIND_SAMPLE;
            sample_d       = {rx_byte_i, low_byte_q};
            count_d        = '0;
            last_d         = (done_inc >= frame_length_q);
            low_byte_d     = 8'd0;
            if (done_inc >= frame_length_q) begin
              phase_d = PH_HUNT;
            end
          end
        end
        default: begin
          phase_d = hunt_next(phase_q, rx_byte_i);
        end
      endcase
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_HUNT;
      frame_length_q   <= 16'd0;
      low_byte_q       <= 8'd0;
      samples_done_q   <= 16'd0;
      pair_half_q      <= 1'b0;
      expected_count_q <= CountReset;
      out_valid_q      <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      frame_length_q <= frame_length_d;
      low_byte_q     <= low_byte_d;
      samples_done_q <= samples_done_d;
      pair_half_q    <= pair_half_d;
      out_valid_q    <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        expected_count_q <= cfg_data_i;
      end
    end
  end

  // result payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q   <= kind_d;
      sample_q <= sample_d;
      count_q  <= count_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign sample_o         = sample_q;
  assign reported_count_o = count_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire

[bench/sync_length_frame_deframer_unit_tb.sv]
`timescale 1ns / 1ps

module sync_length_frame_deframer_unit_tb;
  import sld_pkg::*;

  localparam int QuietLimit = 1000;
  localparam int HoldCycles = 60;

  typedef struct packed {
    kind_e                 kind;
    logic signed [15:0]    sample;
    logic [CountWidth-1:0] count;
    logic                  last;
  } frame_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            rx_byte = 8'h00;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CountWidth-1:0] cfg_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            kind;
  logic signed [15:0]    sample;
  logic [CountWidth-1:0] reported_count;
  logic                  last;

  // predictor state
  phase_e                rx_phase = PH_HUNT;
  logic [15:0]           announced_len = '0;
  logic [7:0]            held_low = '0;
  logic [15:0]           samples_seen = '0;
  logic                  high_next = 1'b0;
  logic [CountWidth-1:0] want_count = CountReset;

  frame_result_t         pending_results[$];
  int                    mismatches = 0;
  int                    quiet_cycles = 0;
  int                    bytes_sent = 0;
  bit                    send_idle = 1'b0;
  bit                    recv_idle = 1'b0;
  bit                    hold_req = 1'b0;
  int                    hold_left = 0;
  int                    stall_left = 0;

  logic [7:0] sync_letters [4] = '{SYNC_0, SYNC_1, SYNC_2, SYNC_3};

  sync_length_frame_deframer_unit u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .rx_byte_i        (rx_byte),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .kind_o           (kind),
    .sample_o         (sample),
    .reported_count_o (reported_count),
    .last_o           (last)
  );

  initial forever #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic phase_e sync_step(input phase_e p, input logic [7:0] b);
    logic [7:0] want;
    phase_e     nxt;
    case (p)
      PH_A: begin
        want = SYNC_1;
        nxt  = PH_AB;
      end
      PH_AB: begin
        want = SYNC_2;
        nxt  = PH_ABC;
      end
      PH_ABC: begin
        want = SYNC_3;
        nxt  = PH_LEN_LO;
      end
      default: begin
        want = SYNC_0;
        nxt  = PH_A;
      end
    endcase
    if (b == want) return nxt;
    if (b == SYNC_0) return PH_A;
    return PH_HUNT;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output frame_result_t r);
    logic [CountWidth-1:0] cnt;
    bit                    made;
    r    = '0;
    made = 1'b0;
    case (rx_phase)
      PH_A, PH_AB, PH_ABC: rx_phase = sync_step(rx_phase, b);
      PH_LEN_LO: begin
        held_low = b;
        rx_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        announced_len = {b, held_low};
        held_low      = '0;
        cnt           = announced_len[15:1];
        made          = 1'b1;
        r.count       = cnt;
        if (cnt == want_count) begin
          r.kind       = KIND_ACCEPT;
          r.last       = (announced_len == 16'd0);
          samples_seen = '0;
          high_next    = 1'b0;
          rx_phase     = r.last ? PH_HUNT : PH_SAMPLES;
        end else begin
          r.kind   = KIND_REJECT;
          rx_phase = PH_HUNT;
        end
      end
      PH_SAMPLES: begin
        if (!high_next) begin
          held_low  = b;
          high_next = 1'b1;
        end else begin
          high_next    = 1'b0;
          samples_seen = samples_seen + 16'd1;
          made         = 1'b1;
          r.kind       = KIND_SAMPLE;
          r.sample     = {b, held_low};
          r.last       = (samples_seen >= announced_len);
          held_low     = '0;
          if (r.last) rx_phase = PH_HUNT;
        end
      end
      default: rx_phase = sync_step(PH_HUNT, b);
    endcase
    return made;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    frame_result_t exp_r;
    frame_result_t new_r;
    bit            busy;
    busy = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        busy = 1'b1;
        if (deframe_byte(rx_byte, new_r)) pending_results.push_back(new_r);
      end
      if (cfg_valid && cfg_ready) begin
        busy       = 1'b1;
        want_count = cfg_data;
      end
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result kind %0d with nothing expected", kind));
        end else begin
          exp_r = pending_results.pop_front();
          if (kind !== exp_r.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind, exp_r.kind));
          if (sample !== exp_r.sample)
            report_mismatch($sformatf("sample %0d, expected %0d", sample, exp_r.sample));
          if (reported_count !== exp_r.count)
            report_mismatch($sformatf("reported_count %0d, expected %0d",
                                      reported_count, exp_r.count));
          if (last !== exp_r.last)
            report_mismatch($sformatf("last %0b, expected %0b", last, exp_r.last));
        end
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
    end
  end

  // receiver side stall pattern
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_idle && stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (recv_idle) stall_left = pick_gap();
      end
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk);
    $display("sync_length_frame_deframer_unit_tb failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
    gap = send_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_sync();
    for (int i = 0; i < 4; i++) send_byte(sync_letters[i]);
  endtask

  task automatic send_header(input logic [15:0] len);
    send_sync();
    send_byte(len[7:0]);
    send_byte(len[15:8]);
  endtask

  task automatic send_frame(input logic [15:0] len);
    send_header(len);
    for (int i = 0; i < 2 * int'(len); i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CountWidth-1:0] value);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_rejected_headers();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_header(16'h0000);
    send_header(16'hFFFF);
    send_header(16'h07FF);
  endtask

  task automatic test_empty_and_odd_frames();
    cfg_write(15'd0);
    send_header(16'h0000);
    send_header(16'h0001);
    send_byte(8'h00);
    send_byte(8'h80);
  endtask

  task automatic test_sync_recovery();
    cfg_write(15'd2);
    send_byte(SYNC_0);
    send_byte(SYNC_0);
    send_byte(SYNC_1);
    send_byte(SYNC_2);
    send_byte(SYNC_0);
    send_byte(SYNC_1);
    send_byte(SYNC_2);
    send_byte(SYNC_3);
    send_byte(8'h04);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h34);
    send_byte(8'h12);
    send_byte(SYNC_0);
    send_byte(SYNC_1);
    send_byte(8'h45);
    send_byte(SYNC_0);
    send_byte(SYNC_1);
    send_byte(SYNC_2);
    send_byte(8'h45);
  endtask

  task automatic test_largest_count();
    cfg_write(15'h7FFF);
    send_header(16'hFFFC);
    send_header(16'h0001);
  endtask

  task automatic test_random_traffic();
    logic [CountWidth-1:0] c;
    logic [15:0]           len;
    logic [7:0]            b;
    int                    stop_at;
    int                    pick;
    int                    k;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) c = '0;
      else if (ph == 5) c = CountWidth'($urandom_range(7, 12));
      else c = CountWidth'($urandom_range(1, 6));
      cfg_write(c);
      send_idle = (ph == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      recv_idle = (ph == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      stop_at = bytes_sent + 72;
      while (bytes_sent < stop_at) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          send_frame({c, 1'b0} | 16'($urandom_range(0, 1)));
        end else if (pick == 6) begin
          len = 16'($urandom);
          if (len[15:1] == c) len[15] = ~len[15];
          send_header(len);
        end else if (pick == 7) begin
          k = $urandom_range(1, 6);
          repeat (k) begin
            if ($urandom_range(0, 1)) send_byte(sync_letters[$urandom_range(0, 3)]);
            else send_byte(8'($urandom_range(0, 255)));
          end
        end else begin
          k = $urandom_range(1, 3);
          for (int i = 0; i < k; i++) send_byte(sync_letters[i]);
          b = 8'($urandom_range(0, 255));
          if (b == sync_letters[k]) b = SYNC_0;
          send_byte(b);
        end
      end
    end
  endtask

  task automatic test_output_hold();
    cfg_write(15'd6);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_req  = 1'b1;
    @(negedge clk);
    send_frame(16'd13);
    send_frame(16'd12);
  endtask

  task automatic test_sender_pause();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    send_frame(16'd12);
    wait_drain();
    send_frame(16'd13);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    test_rejected_headers();
    test_empty_and_odd_frames();
    test_sync_recovery();
    test_largest_count();
    test_random_traffic();
    test_output_hold();
    test_sender_pause();
    wait_drain();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("sync_length_frame_deframer_unit_tb passed");
    end else begin
      $display("sync_length_frame_deframer_unit_tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sld_pkg.sv
rtl/sync_length_frame_deframer_unit.sv
bench/sync_length_frame_deframer_unit_tb.sv
